>>> hw/rtl/lmdt_pkg.sv
// Shared types, register indexes and helpers for the level meter with delayed trail.
package lmdt_pkg;

  localparam int LEVEL_W    = 24;
  localparam int RATE_W     = 16;
  localparam int TICK_W     = 10;
  localparam int HOLD_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = TICK_W + RATE_W;

  typedef logic [LEVEL_W-1:0] level_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_RESTART = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRAPPED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSTANT = 2'd2;

  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_SET  = 1'b1;

  localparam level_t MAX_LEVEL_RESET  = 24'd25600;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

  typedef struct packed {
    logic               action;
    logic [TICK_W-1:0]  elapsed_ticks;
    level_t             new_level;
    logic [MODE_W-1:0]  set_mode;
  } item_t;

  typedef struct packed {
    level_t shown_level;
    level_t trail_level;
  } result_t;

  typedef struct packed {
    level_t             max_level;
    logic [HOLD_W-1:0]  hold_ticks;
    logic               always_restart;
  } cfg_t;

  typedef struct packed {
    logic               set;
    logic [MODE_W-1:0]  mode;
    logic [TICK_W-1:0]  ticks;
    level_t             level;
    level_t             step;
    level_t             decay;
  } op_t;

  function automatic level_t sat_level(input logic [PROD_W-1:0] prod);
    sat_level = (|prod[PROD_W-1:LEVEL_W]) ? '1 : prod[LEVEL_W-1:0];
  endfunction

endpackage

>>> hw/rtl/lmdt_step.sv
// Meter state registers with the tick and set update logic.
module lmdt_step import lmdt_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  op_t     op,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int CW = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
  localparam int HW = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

  level_t                shown;
  level_t                target;
  level_t                trail;
  logic                  wrap_flag;
  logic [TIMER_BITS-1:0] hold_timer;

  logic [CW-1:0]         hold_ext;
  logic [CW-1:0]         ticks_ext;
  logic [TIMER_BITS-1:0] hold_dec;
  logic [HW-1:0]         reload_ext;
  logic [TIMER_BITS-1:0] hold_reload;

  logic [LEVEL_W:0]      sum_up;
  logic [LEVEL_W:0]      over;
  level_t                diff_down;
  level_t                wrap_low;
  level_t                dec_down;
  level_t                shown_tick;
  level_t                trail_base;
  level_t                trail_decayed;
  level_t                trail_tick;
  logic                  wrap_tick;
  logic                  changed;

  always_comb begin
    hold_ext    = CW'(hold_timer);
    ticks_ext   = CW'(op.ticks);
    hold_dec    = (hold_ext > ticks_ext) ? TIMER_BITS'(hold_ext - ticks_ext) : '0;
    reload_ext  = HW'(cfg.hold_ticks);
    hold_reload = reload_ext[TIMER_BITS-1:0];
    changed     = (op.level != target);
  end

  always_comb begin
    sum_up     = {1'b0, shown} + {1'b0, op.step};
    over       = sum_up - {1'b0, cfg.max_level};
    diff_down  = op.step - shown;
    wrap_low   = cfg.max_level - diff_down;
    dec_down   = shown - op.step;
    shown_tick = shown;
    wrap_tick  = wrap_flag;
    trail_base = trail;
    if (shown < target) begin
      if (wrap_flag) begin
        if (op.step > shown) begin
          if (diff_down > cfg.max_level || wrap_low < target) begin
            shown_tick = target;
          end else begin
            shown_tick = wrap_low;
          end
          wrap_tick  = 1'b0;
          trail_base = cfg.max_level;
        end else begin
          shown_tick = dec_down;
        end
      end else if (sum_up < {1'b0, target}) begin
        shown_tick = sum_up[LEVEL_W-1:0];
      end else begin
        shown_tick = target;
      end
    end else if (shown > target) begin
      if (wrap_flag) begin
        if (sum_up > {1'b0, cfg.max_level}) begin
          if (over < {1'b0, target}) begin
            shown_tick = over[LEVEL_W-1:0];
          end else begin
            shown_tick = target;
          end
          wrap_tick  = 1'b0;
          trail_base = shown_tick;
        end else begin
          shown_tick = sum_up[LEVEL_W-1:0];
        end
      end else if (op.step > shown || dec_down < target) begin
        shown_tick = target;
      end else begin
        shown_tick = dec_down;
      end
    end
  end

  always_comb begin
    trail_decayed = trail_base - op.decay;
    if (trail_base < shown_tick) begin
      trail_tick = shown_tick;
    end else if (trail_base > shown_tick && hold_dec == '0) begin
      if (op.decay > trail_base || trail_decayed < shown_tick) begin
        trail_tick = shown_tick;
      end else begin
        trail_tick = trail_decayed;
      end
    end else begin
      trail_tick = trail_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown      <= '0;
      target     <= '0;
      trail      <= '0;
      wrap_flag  <= 1'b0;
      hold_timer <= '0;
    end else if (load) begin
      if (op.set) begin
        if (changed) begin
          if (cfg.always_restart || shown == trail) begin
            hold_timer <= hold_reload;
          end
          wrap_flag <= (op.mode == MODE_WRAPPED);
          target    <= op.level;
          if (op.mode == MODE_INSTANT) begin
            shown <= op.level;
          end
        end
      end else begin
        shown      <= shown_tick;
        trail      <= trail_tick;
        wrap_flag  <= wrap_tick;
        hold_timer <= hold_dec;
      end
    end
  end

  assign result.shown_level = shown;
  assign result.trail_level = trail;

endmodule

>>> hw/rtl/level_meter_with_delayed_trail_unit.sv
// Top level of the level meter with delayed trail: configuration, request stage and handshake.
// The unit accepts one request per clock cycle while item_stall is low. The request register
// takes the request together with the saturated fill and decay products and the target
// clamped to the maximum level; the meter state registers are then updated from it and are
// the result shown on the output. A held result stalls the request stage, so a new request
// is still taken while one result waits only if the request stage is empty.
module level_meter_with_delayed_trail_unit import lmdt_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  level_t            max_level;
  logic [RATE_W-1:0] fill_rate;
  logic [RATE_W-1:0] trail_rate;
  logic [HOLD_W-1:0] hold_ticks;
  logic              always_restart;
  cfg_t              cfg;

  op_t               op;
  op_t               op_next;
  logic              op_valid;
  logic              advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level      <= MAX_LEVEL_RESET;
      fill_rate      <= RATE_RESET;
      trail_rate     <= RATE_RESET;
      hold_ticks     <= '0;
      always_restart <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_LEVEL:      max_level      <= cfg_data[LEVEL_W-1:0];
        CFG_FILL_RATE:      fill_rate      <= cfg_data[RATE_W-1:0];
        CFG_TRAIL_RATE:     trail_rate     <= cfg_data[RATE_W-1:0];
        CFG_HOLD_TICKS:     hold_ticks     <= cfg_data[HOLD_W-1:0];
        CFG_ALWAYS_RESTART: always_restart <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.max_level      = max_level;
  assign cfg.hold_ticks     = hold_ticks;
  assign cfg.always_restart = always_restart;

  always_comb begin
    op_next.set   = (item.action == ACTION_SET);
    op_next.mode  = item.set_mode;
    op_next.ticks = item.elapsed_ticks;
    op_next.level = (item.new_level < max_level) ? item.new_level : max_level;
    op_next.step  = sat_level(PROD_W'(item.elapsed_ticks) * PROD_W'(fill_rate));
    op_next.decay = sat_level(PROD_W'(item.elapsed_ticks) * PROD_W'(trail_rate));
  end

  assign advance    = !result_valid || !result_stall;
  assign item_stall = op_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= op_valid;
      end
      if (!item_stall) begin
        op_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      op <= op_next;
    end
  end

  lmdt_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .load   (op_valid && advance),
    .op     (op),
    .cfg    (cfg),
    .result (result)
  );

endmodule

>>> test/tb_level_meter_with_delayed_trail_unit.sv
// Self-checking testbench for the level meter with delayed trail, with its own prediction.
`timescale 1ns / 100ps

module tb_level_meter_with_delayed_trail_unit;
  import lmdt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int QUIET_FIRST = 600;
  localparam int QUIET_LAST = 900;
  localparam logic [63:0] LEVEL_ALL = 64'hFF_FFFF;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    item_t                 req;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // Copy of the configuration registers and of the meter state.
  level_t c_max = MAX_LEVEL_RESET;
  logic [RATE_W-1:0] c_fill = RATE_RESET;
  logic [RATE_W-1:0] c_decay_rate = RATE_RESET;
  logic [HOLD_W-1:0] c_hold = '0;
  logic c_restart = 1'b0;

  level_t m_shown = '0;
  level_t m_target = '0;
  level_t m_trail = '0;
  logic m_wrap = 1'b0;
  logic [HOLD_W-1:0] m_hold = '0;

  entry_t pending_items[$];
  result_t expected_levels[$];
  result_t want;
  level_t last_level = '0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  logic quiet;

  assign quiet = (items_accepted >= QUIET_FIRST) && (items_accepted < QUIET_LAST);

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  level_meter_with_delayed_trail_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  function automatic item_t make_req(input logic act, input logic [TICK_W-1:0] ticks,
                                     input level_t level, input logic [MODE_W-1:0] mode);
    item_t r;
    r = '0;
    r.action = act;
    r.elapsed_ticks = ticks;
    r.new_level = level;
    r.set_mode = mode;
    return r;
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    entry_t e;
    e = '0;
    e.is_cfg = 1'b1;
    e.cfg_idx = idx;
    e.cfg_val = val;
    pending_items.push_back(e);
  endtask

  task automatic add_item(input item_t r);
    entry_t e;
    e = '0;
    e.req = r;
    pending_items.push_back(e);
    items_queued++;
  endtask

  task automatic predict(input item_t r);
    logic [63:0] dt;
    logic [63:0] step;
    logic [63:0] decay;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] v;
    logic [63:0] sh;
    logic [63:0] tg;
    logic [63:0] tr;
    logic [63:0] mx;
    result_t res;
    dt = 64'(r.elapsed_ticks);
    mx = 64'(c_max);
    sh = 64'(m_shown);
    tg = 64'(m_target);
    tr = 64'(m_trail);
    if (r.action == ACTION_SET) begin
      e = (64'(r.new_level) < mx) ? 64'(r.new_level) : mx;
      if (e != tg) begin
        if (c_restart || sh == tr) begin
          m_hold = c_hold;
        end
        m_wrap = (r.set_mode == MODE_WRAPPED);
        m_target = level_t'(e);
        if (r.set_mode == MODE_INSTANT) begin
          m_shown = level_t'(e);
        end
      end
    end else begin
      step = dt * 64'(c_fill);
      if (step > LEVEL_ALL) begin
        step = LEVEL_ALL;
      end
      decay = dt * 64'(c_decay_rate);
      if (decay > LEVEL_ALL) begin
        decay = LEVEL_ALL;
      end
      if (64'(m_hold) > dt) begin
        m_hold = HOLD_W'(64'(m_hold) - dt);
      end else begin
        m_hold = '0;
      end
      if (sh < tg) begin
        if (m_wrap) begin
          if (step > sh) begin
            d = step - sh;
            v = (d > mx) ? tg : mx - d;
            sh = (v > tg) ? v : tg;
            m_wrap = 1'b0;
            tr = mx;
          end else begin
            sh = sh - step;
          end
        end else begin
          s = sh + step;
          sh = (s < tg) ? s : tg;
        end
      end else if (sh > tg) begin
        if (m_wrap) begin
          s = sh + step;
          if (s > mx) begin
            v = s - mx;
            sh = (v < tg) ? v : tg;
            m_wrap = 1'b0;
            tr = sh;
          end else begin
            sh = s;
          end
        end else if (step > sh) begin
          sh = tg;
        end else begin
          v = sh - step;
          sh = (v > tg) ? v : tg;
        end
      end
      sh = sh & LEVEL_ALL;
      if (tr < sh) begin
        tr = sh;
      end else if (tr > sh && m_hold == '0) begin
        if (decay > tr) begin
          tr = sh;
        end else begin
          v = tr - decay;
          tr = (v > sh) ? v : sh;
        end
      end
      tr = tr & LEVEL_ALL;
      m_shown = level_t'(sh);
      m_trail = level_t'(tr);
    end
    res.shown_level = m_shown;
    res.trail_level = m_trail;
    expected_levels.push_back(res);
  endtask

  always @(posedge clk) begin : driver
    entry_t head;
    logic hold;
    hold = item_valid && item_stall;
    if (rst) begin
      item_valid <= 1'b0;
      cfg_write <= 1'b0;
    end else if (!hold) begin
      if (pending_items.size() == 0) begin
        item_valid <= 1'b0;
        cfg_write <= 1'b0;
      end else begin
        head = pending_items[0];
        if (head.is_cfg) begin
          item_valid <= 1'b0;
          if (!item_valid && items_accepted == results_checked) begin
            cfg_write <= 1'b1;
            cfg_index <= head.cfg_idx;
            cfg_data <= head.cfg_val;
            void'(pending_items.pop_front());
          end else begin
            cfg_write <= 1'b0;
          end
        end else if (!quiet && $urandom_range(99) < 14) begin
          item_valid <= 1'b0;
          cfg_write <= 1'b0;
        end else begin
          item_valid <= 1'b1;
          item <= head.req;
          cfg_write <= 1'b0;
          void'(pending_items.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin : in_monitor
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAX_LEVEL:      c_max = cfg_data[LEVEL_W-1:0];
          CFG_FILL_RATE:      c_fill = cfg_data[RATE_W-1:0];
          CFG_TRAIL_RATE:     c_decay_rate = cfg_data[RATE_W-1:0];
          CFG_HOLD_TICKS:     c_hold = cfg_data[HOLD_W-1:0];
          CFG_ALWAYS_RESTART: c_restart = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        predict(item);
        items_accepted <= items_accepted + 1;
      end
    end
  end

  always @(posedge clk) begin : out_monitor
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: expected no result, actual shown %h trail %h", $time,
                   result.shown_level, result.trail_level);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (result !== want) begin
            $display("%0t: expected shown %h trail %h, actual shown %h trail %h", $time,
                     want.shown_level, want.trail_level, result.shown_level,
                     result.trail_level);
            mismatches++;
          end
        end
        results_checked <= results_checked + 1;
      end
      result_stall <= !quiet && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    item_t r;
    int unsigned p;
    int unsigned n;
    level_t lim;

    add_item(make_req(ACTION_SET, 10'd0, 24'd12800, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd10, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd100, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_SET, 10'd0, 24'd3000, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd5, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd1023, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_SET, 10'd0, 24'd20000, MODE_WRAPPED));
    add_item(make_req(ACTION_TICK, 10'd5, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd20, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd200, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_SET, 10'd0, 24'd1000, MODE_WRAPPED));
    add_item(make_req(ACTION_TICK, 10'd30, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd1023, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_SET, 10'd0, 24'd30000, MODE_INSTANT));
    add_item(make_req(ACTION_SET, 10'd0, 24'd30000, MODE_INSTANT));
    add_item(make_req(ACTION_SET, 10'd0, 24'd500, MODE_UNUSED));
    add_item(make_req(ACTION_TICK, 10'd3, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd0, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_SET, 10'd0, 24'd25600, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd1023, 24'd0, MODE_NORMAL));
    add_cfg(CFG_HOLD_TICKS, 24'd20);
    add_cfg(CFG_ALWAYS_RESTART, 24'd1);
    add_item(make_req(ACTION_SET, 10'd0, 24'd100, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd5, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd10, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd10, 24'd0, MODE_NORMAL));
    add_item(make_req(ACTION_TICK, 10'd1023, 24'd0, MODE_NORMAL));

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: lim = '1;
        1: lim = level_t'($urandom_range(4096));
        default: lim = level_t'($urandom);
      endcase
      add_cfg(CFG_MAX_LEVEL, lim);
      add_cfg(CFG_FILL_RATE, (p == 2) ? 24'h00FFFF : {8'h5A, 16'($urandom_range(2048))});
      add_cfg(CFG_TRAIL_RATE, (p == 5) ? 24'h000000 : {8'hC3, 16'($urandom_range(1024))});
      add_cfg(CFG_HOLD_TICKS, {8'h00, 16'($urandom_range(40))});
      add_cfg(CFG_ALWAYS_RESTART, (p % 2 == 1) ? 24'h000003 : 24'h000002);
      add_cfg(CFG_UNUSED, 24'hFFFFFF);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = '0;
        r.action = ($urandom_range(99) < 35) ? ACTION_SET : ACTION_TICK;
        if ($urandom_range(4) == 0) begin
          r.elapsed_ticks = TICK_W'($urandom);
        end else begin
          r.elapsed_ticks = TICK_W'($urandom_range(6));
        end
        case ($urandom_range(5))
          0: r.new_level = last_level;
          1: r.new_level = level_t'($urandom);
          2: r.new_level = '0;
          default: r.new_level = level_t'($urandom_range(32'(lim)));
        endcase
        r.set_mode = MODE_W'($urandom_range(3));
        if (r.action == ACTION_SET) begin
          last_level = r.new_level;
        end
        add_item(r);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || results_checked != items_queued) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
